>>> rtl/core/three_axis_stepper_homing_jog_macros.svh
// assertion macros for the stepper controller checker
`ifndef THREE_AXIS_STEPPER_HOMING_JOG_MACROS_SVH
`define THREE_AXIS_STEPPER_HOMING_JOG_MACROS_SVH

// clocked assertion, disabled while reset is asserted
`define TASH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// clocked assertion that also holds during reset
`define TASH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> rtl/core/tash_pkg.sv
// shared types, codes and coil step functions for the stepper controller
`timescale 1ns / 1ps

package tash_pkg;

  typedef enum logic [2:0] {
    OP_TICK       = 3'd0,
    OP_ESTOP      = 3'd1,
    OP_RELEASE    = 3'd2,
    OP_ENDSTOP_X  = 3'd3,
    OP_ENDSTOP_Y  = 3'd4,
    OP_ENDSTOP_Z  = 3'd5,
    OP_RSVD_6     = 3'd6,
    OP_RSVD_7     = 3'd7
  } opcode_e;

  typedef enum logic [2:0] {
    REG_JOY_X_LOW   = 3'd0,
    REG_JOY_X_HIGH  = 3'd1,
    REG_JOY_Y_LOW   = 3'd2,
    REG_JOY_Y_HIGH  = 3'd3,
    REG_Z_UP_LOW    = 3'd4,
    REG_Z_UP_HIGH   = 3'd5,
    REG_Z_DOWN_LOW  = 3'd6,
    REG_Z_DOWN_HIGH = 3'd7
  } cfg_reg_e;

  localparam logic [15:0] JOY_X_LOW_RST   = 16'd31000;
  localparam logic [15:0] JOY_X_HIGH_RST  = 16'd32500;
  localparam logic [15:0] JOY_Y_LOW_RST   = 16'd31000;
  localparam logic [15:0] JOY_Y_HIGH_RST  = 16'd34500;
  localparam logic [15:0] Z_UP_LOW_RST    = 16'd6554;
  localparam logic [15:0] Z_UP_HIGH_RST   = 16'd6684;
  localparam logic [15:0] Z_DOWN_LOW_RST  = 16'd16384;
  localparam logic [15:0] Z_DOWN_HIGH_RST = 16'd17039;

  localparam logic [2:0] ALL_HOMED = 3'b111;

  typedef struct packed {
    logic [15:0] joy_x_low;
    logic [15:0] joy_x_high;
    logic [15:0] joy_y_low;
    logic [15:0] joy_y_high;
    logic [15:0] z_up_low;
    logic [15:0] z_up_high;
    logic [15:0] z_down_low;
    logic [15:0] z_down_high;
  } cfg_t;

  typedef struct packed {
    logic       run;
    logic [2:0] homed;
    logic [3:0] coils_z;
    logic [3:0] coils_y;
    logic [3:0] coils_x;
  } axis_state_t;

  function automatic logic [3:0] step_fwd(logic [3:0] c);
    logic [3:0] r;
    if (c == 4'd0) begin
      r = 4'b0001;
    end else begin
      r = {c[2:0], c[3]};
    end
    return r;
  endfunction

  function automatic logic [3:0] step_rev(logic [3:0] c);
    logic [3:0] r;
    if (c == 4'd0) begin
      r = 4'b1000;
    end else begin
      r = {c[0], c[3:1]};
    end
    return r;
  endfunction

endpackage

>>> rtl/core/tash_step.sv
// next-state logic for one tick or event item
`timescale 1ns / 1ps

module tash_step import tash_pkg::*; (
  input  axis_state_t state_i,
  input  cfg_t        cfg_i,
  input  opcode_e     opcode_i,
  input  logic [15:0] joy_x_i,
  input  logic [15:0] joy_y_i,
  input  logic [15:0] level_i,
  output axis_state_t state_o
);

  logic z_up_hit;
  logic z_down_hit;

  assign z_up_hit   = (level_i >= cfg_i.z_up_low) && (level_i <= cfg_i.z_up_high);
  assign z_down_hit = (level_i >= cfg_i.z_down_low) && (level_i <= cfg_i.z_down_high);

  always_comb begin
    logic [3:0] z_tmp;
    logic       all_homed;
    state_o   = state_i;
    all_homed = (state_i.homed == ALL_HOMED);
    z_tmp     = state_i.coils_z;
    case (opcode_i)
      OP_TICK: begin
        if (state_i.run) begin
          if (!all_homed) begin
            // homing: unhomed axes creep forward
            if (!state_i.homed[0]) state_o.coils_x = step_fwd(state_i.coils_x);
            if (!state_i.homed[1]) state_o.coils_y = step_fwd(state_i.coils_y);
            if (!state_i.homed[2]) state_o.coils_z = step_fwd(state_i.coils_z);
          end else begin
            if (joy_x_i > cfg_i.joy_x_high) begin
              state_o.coils_x = step_fwd(state_i.coils_x);
            end else if (joy_x_i < cfg_i.joy_x_low) begin
              state_o.coils_x = step_rev(state_i.coils_x);
            end
            if (joy_y_i > cfg_i.joy_y_high) begin
              state_o.coils_y = step_fwd(state_i.coils_y);
            end else if (joy_y_i < cfg_i.joy_y_low) begin
              state_o.coils_y = step_rev(state_i.coils_y);
            end
            // both windows hit: forward then reverse
            if (z_up_hit) z_tmp = step_fwd(z_tmp);
            if (z_down_hit) z_tmp = step_rev(z_tmp);
            state_o.coils_z = z_tmp;
          end
        end
      end
      OP_ESTOP: begin
        state_o.run   = 1'b0;
        state_o.homed = 3'b000;
      end
      OP_RELEASE: begin
        state_o.run = 1'b1;
      end
      OP_ENDSTOP_X, OP_ENDSTOP_Y, OP_ENDSTOP_Z: begin
        if (state_i.run) begin
          if (all_homed) begin
            // crash
            state_o.run   = 1'b0;
            state_o.homed = 3'b000;
          end else if (opcode_i == OP_ENDSTOP_X) begin
            state_o.homed[0] = 1'b1;
            state_o.coils_x  = 4'd0;
          end else if (opcode_i == OP_ENDSTOP_Y) begin
            state_o.homed[1] = 1'b1;
            state_o.coils_y  = 4'd0;
          end else begin
            state_o.homed[2] = 1'b1;
            state_o.coils_z  = 4'd0;
          end
        end
      end
      default: begin
        state_o = state_i;
      end
    endcase
  end

endmodule

>>> rtl/core/three_axis_stepper_homing_jog.sv
// top level of the three-axis stepper homing and jog controller
`timescale 1ns / 1ps

// Drives three wave-drive stepper axes from a stream of tick and event items,
// one result per item showing coils, homed flags and run state after it.
// One item is accepted every clock while the input is not stalled; a result
// passes the input register, the state update and the result register.
// Back-pressure on the result side stalls the input only once both registers
// are full. The user must write thresholds through the configuration port
// only while no item is in flight; the block itself does not enforce it.

module three_axis_stepper_homing_jog import tash_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // joy_x, joy_y, button_level
  input  logic [2:0]  s_axis_tuser,  // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // coils_x, coils_y, coils_z, homed_mask, running
);

  cfg_t        cfg_q;
  axis_state_t state_q;
  axis_state_t state_d;

  logic        in_valid_q;
  opcode_e     op_q;
  logic [15:0] joy_x_q;
  logic [15:0] joy_y_q;
  logic [15:0] level_q;

  logic        out_valid_q;
  logic [15:0] out_data_q;
  logic        advance;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.joy_x_low   <= JOY_X_LOW_RST;
      cfg_q.joy_x_high  <= JOY_X_HIGH_RST;
      cfg_q.joy_y_low   <= JOY_Y_LOW_RST;
      cfg_q.joy_y_high  <= JOY_Y_HIGH_RST;
      cfg_q.z_up_low    <= Z_UP_LOW_RST;
      cfg_q.z_up_high   <= Z_UP_HIGH_RST;
      cfg_q.z_down_low  <= Z_DOWN_LOW_RST;
      cfg_q.z_down_high <= Z_DOWN_HIGH_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_JOY_X_LOW:   cfg_q.joy_x_low   <= cfg_data_i;
        REG_JOY_X_HIGH:  cfg_q.joy_x_high  <= cfg_data_i;
        REG_JOY_Y_LOW:   cfg_q.joy_y_low   <= cfg_data_i;
        REG_JOY_Y_HIGH:  cfg_q.joy_y_high  <= cfg_data_i;
        REG_Z_UP_LOW:    cfg_q.z_up_low    <= cfg_data_i;
        REG_Z_UP_HIGH:   cfg_q.z_up_high   <= cfg_data_i;
        REG_Z_DOWN_LOW:  cfg_q.z_down_low  <= cfg_data_i;
        REG_Z_DOWN_HIGH: cfg_q.z_down_high <= cfg_data_i;
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      op_q    <= opcode_e'(s_axis_tuser);
      joy_x_q <= s_axis_tdata[15:0];
      joy_y_q <= s_axis_tdata[31:16];
      level_q <= s_axis_tdata[47:32];
    end
  end

  tash_step u_step (
    .state_i  (state_q),
    .cfg_i    (cfg_q),
    .opcode_i (op_q),
    .joy_x_i  (joy_x_q),
    .joy_y_i  (joy_y_q),
    .level_i  (level_q),
    .state_o  (state_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.run     <= 1'b1;
      state_q.homed   <= 3'b000;
      state_q.coils_x <= 4'd0;
      state_q.coils_y <= 4'd0;
      state_q.coils_z <= 4'd0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= {state_d.run, state_d.homed, state_d.coils_z,
                     state_d.coils_y, state_d.coils_x};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

>>> rtl/core/tash_checker.sv
// port-level assertions for the stepper controller, bound to the top level
`timescale 1ns / 1ps
`include "three_axis_stepper_homing_jog_macros.svh"

module tash_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  // every coil drive is one-hot or off
  `TASH_ASSERT(a_coils_onehot0, m_axis_tvalid |-> ($onehot0(m_axis_tdata[3:0]) && $onehot0(m_axis_tdata[7:4]) && $onehot0(m_axis_tdata[11:8])), "coil drive not one-hot or zero")

  // emergency state never reports a homed axis
  `TASH_ASSERT(a_stop_unhomed, (m_axis_tvalid && !m_axis_tdata[15]) |-> (m_axis_tdata[14:12] == 3'b000), "homed flag set in emergency state")

  // a stalled result holds
  `TASH_ASSERT(a_out_hold, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)), "stalled result changed")

  // no result and no stall while in reset
  `TASH_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> (!m_axis_tvalid && s_axis_tready), "result shown during reset")

endmodule

bind three_axis_stepper_homing_jog tash_checker u_tash_checker (.*);
